### rtl/core/bsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bad sector recorder package
// Shared widths, status codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int TABLE_ENTRIES_DEF = 126;

    localparam int BN_W       = 24;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int CYL_W      = 16;
    localparam int TRK_W      = 8;
    localparam int SEC_W      = 8;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 7;
    localparam int TOTAL_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = BN_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int KINDS      = 4;

    localparam logic [CYL_W-1:0]   SPC_RESET  = 16'd640;
    localparam logic [TRK_W-1:0]   SPT_RESET  = 8'd32;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 16'hFFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_BAD    = 3'd0,
        ST_SKIP   = 3'd1,
        ST_BURNIN = 3'd2,
        ST_DUP    = 3'd3,
        ST_SPARE  = 3'd4,
        ST_FULL   = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPT    = 2'd0,
        REG_SPC    = 2'd1,
        REG_SKIP   = 2'd2,
        REG_BURNIN = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DIV_CYL,
        S_DIV_TRK,
        S_NORM
    } t_state;

endpackage

### rtl/core/bsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bad sector recorder RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module bsr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 252
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bad_sector_recorder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bad sector recorder core
// Records one failing block per command: a unique-block list in burn-in mode,
// otherwise bad-sector or skip-sector table entries; a kind histogram in both.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears on
// the output ports for exactly one cycle with o_done high and cannot be held
// off. In burn-in mode a command runs the duplicate search over the list, one
// entry a cycle from the list RAM, before its result beat. In normal mode a
// bit-serial divider runs twice, first for the cylinder and then for the track
// and sector, before the result beat.
module bad_sector_recorder_core #(
    parameter int TABLE_ENTRIES = bsr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bsr_pkg::BN_W-1:0]       i_block_number,
    input  logic [bsr_pkg::KIND_W-1:0]     i_error_kind,
    input  logic                           i_cfg_we,
    input  logic [bsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_done,
    output logic [bsr_pkg::STATUS_W-1:0]   o_status,
    output logic [bsr_pkg::CYL_W-1:0]      o_cylinder,
    output logic [bsr_pkg::TRK_W-1:0]      o_track,
    output logic [bsr_pkg::SEC_W-1:0]      o_sector,
    output logic [bsr_pkg::IDX_W-1:0]      o_entry_index,
    output logic [bsr_pkg::CNT_W-1:0]      o_bad_count,
    output logic [bsr_pkg::CNT_W-1:0]      o_skip_count,
    output logic [bsr_pkg::TOTAL_W-1:0]    o_kind_total
);

    import bsr_pkg::*;

    localparam int LIST_DEPTH = 2 * TABLE_ENTRIES;
    localparam int AW         = $clog2(LIST_DEPTH);
    localparam int LCW        = $clog2(LIST_DEPTH + 1);
    localparam int TCW        = $clog2(TABLE_ENTRIES + 1);

    t_state               r_state, n_state;
    logic [TRK_W-1:0]     r_spt;
    logic [CYL_W-1:0]     r_spc;
    logic                 r_skip_drive;
    logic                 r_burnin;

    logic [BN_W-1:0]      r_bn, n_bn;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [LCW-1:0]       r_idx, n_idx;
    logic [LCW-1:0]       r_pidx, n_pidx;
    logic                 r_pend, n_pend;
    logic [BN_W-1:0]      r_q, n_q;
    logic [CYL_W-1:0]     r_rem, n_rem;
    logic [CYL_W-1:0]     r_dvs, n_dvs;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [CYL_W-1:0]     r_cyl, n_cyl;
    logic [TRK_W-1:0]     r_trk, n_trk;
    logic [SEC_W-1:0]     r_sec, n_sec;
    logic [LCW-1:0]       r_bcount, n_bcount;
    logic [TCW-1:0]       r_bad, n_bad;
    logic [TCW-1:0]       r_skip, n_skip;
    logic [CYL_W-1:0]     r_last_cyl, n_last_cyl;
    logic [TRK_W-1:0]     r_last_trk, n_last_trk;
    logic [TOTAL_W-1:0]   r_hist [KINDS];
    logic                 n_hist_we;
    logic [TOTAL_W-1:0]   n_hist_val;

    logic                 r_done, n_done;
    t_status              r_status, n_status;
    logic [CYL_W-1:0]     r_o_cyl, n_o_cyl;
    logic [TRK_W-1:0]     r_o_trk, n_o_trk;
    logic [SEC_W-1:0]     r_o_sec, n_o_sec;
    logic [IDX_W-1:0]     r_o_idx, n_o_idx;
    logic [CNT_W-1:0]     r_o_bad, n_o_bad;
    logic [CNT_W-1:0]     r_o_skip, n_o_skip;
    logic [TOTAL_W-1:0]   r_o_total, n_o_total;

    logic                 ram_we;
    logic [BN_W-1:0]      ram_rdata;

    logic [CYL_W:0]       div_shift;
    logic [CYL_W:0]       div_diff;
    logic                 div_ge;
    logic [CYL_W-1:0]     div_rem;
    logic [BN_W-1:0]      div_q;
    logic [TRK_W-1:0]     spt_eff;
    logic                 kind_counted;
    logic [TOTAL_W-1:0]   hist_cur;
    logic [TOTAL_W-1:0]   hist_inc;
    logic [31:0]          idx_wide;
    logic [31:0]          bad_wide;
    logic [31:0]          skip_wide;
    logic                 to_bad;
    logic                 new_track;

    bsr_ram #(
        .WIDTH (BN_W),
        .DEPTH (LIST_DEPTH)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_bcount[AW-1:0]),
        .i_wdata (r_bn),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign div_shift = {r_rem, r_q[BN_W-1]};
    assign div_diff  = div_shift - {1'b0, r_dvs};
    assign div_ge    = div_shift >= {1'b0, r_dvs};
    assign div_rem   = div_ge ? div_diff[CYL_W-1:0] : div_shift[CYL_W-1:0];
    assign div_q     = {r_q[BN_W-2:0], div_ge};

    assign spt_eff      = (r_spt == '0) ? TRK_W'(1) : r_spt;
    assign kind_counted = r_kind < KIND_W'(KINDS);
    assign hist_cur     = r_hist[r_kind[1:0]];
    assign hist_inc     = (hist_cur == TOTAL_MAX) ? hist_cur : hist_cur + TOTAL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_spt        <= SPT_RESET;
            r_spc        <= SPC_RESET;
            r_skip_drive <= 1'b0;
            r_burnin     <= 1'b0;
            r_bcount     <= '0;
            r_bad        <= '0;
            r_skip       <= '0;
            r_pend       <= 1'b0;
            r_done       <= 1'b0;
            for (int k = 0; k < KINDS; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_bcount <= n_bcount;
            r_bad    <= n_bad;
            r_skip   <= n_skip;
            r_pend   <= n_pend;
            r_done   <= n_done;
            if (n_hist_we) begin
                r_hist[r_kind[1:0]] <= n_hist_val;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_SPT:    r_spt        <= i_cfg_data[TRK_W-1:0];
                    REG_SPC:    r_spc        <= i_cfg_data[CYL_W-1:0];
                    REG_SKIP:   r_skip_drive <= i_cfg_data[0];
                    REG_BURNIN: r_burnin     <= i_cfg_data[0];
                    default:    r_burnin     <= r_burnin;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bn       <= n_bn;
        r_kind     <= n_kind;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_dvs      <= n_dvs;
        r_step     <= n_step;
        r_cyl      <= n_cyl;
        r_trk      <= n_trk;
        r_sec      <= n_sec;
        r_last_cyl <= n_last_cyl;
        r_last_trk <= n_last_trk;
        r_status   <= n_status;
        r_o_cyl    <= n_o_cyl;
        r_o_trk    <= n_o_trk;
        r_o_sec    <= n_o_sec;
        r_o_idx    <= n_o_idx;
        r_o_bad    <= n_o_bad;
        r_o_skip   <= n_o_skip;
        r_o_total  <= n_o_total;
    end

    always_comb begin
        n_state    = r_state;
        n_bn       = r_bn;
        n_kind     = r_kind;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_pend     = 1'b0;
        n_q        = r_q;
        n_rem      = r_rem;
        n_dvs      = r_dvs;
        n_step     = r_step;
        n_cyl      = r_cyl;
        n_trk      = r_trk;
        n_sec      = r_sec;
        n_bcount   = r_bcount;
        n_bad      = r_bad;
        n_skip     = r_skip;
        n_last_cyl = r_last_cyl;
        n_last_trk = r_last_trk;
        n_hist_we  = 1'b0;
        n_hist_val = hist_inc;
        n_done     = 1'b0;
        n_status   = r_status;
        n_o_cyl    = r_o_cyl;
        n_o_trk    = r_o_trk;
        n_o_sec    = r_o_sec;
        n_o_idx    = r_o_idx;
        n_o_bad    = r_o_bad;
        n_o_skip   = r_o_skip;
        n_o_total  = r_o_total;
        ram_we     = 1'b0;
        idx_wide   = '0;
        bad_wide   = 32'(r_bad);
        skip_wide  = 32'(r_skip);
        to_bad     = 1'b1;
        new_track  = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_bn   = i_block_number;
                    n_kind = i_error_kind;
                    n_idx  = '0;
                    n_q    = i_block_number;
                    n_rem  = '0;
                    n_dvs  = (r_spc == '0) ? CYL_W'(1) : r_spc;
                    n_step = '0;
                    n_state = r_burnin ? S_SEARCH : S_DIV_CYL;
                end
            end
            S_SEARCH: begin
                if (r_pend && ram_rdata == r_bn) begin
                    idx_wide  = 32'(r_pidx);
                    n_status  = ST_DUP;
                    n_o_total = kind_counted ? hist_cur : '0;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_idx < r_bcount) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + LCW'(1);
                end else if (!r_pend) begin
                    if (r_bcount >= (r_skip_drive ? LCW'(LIST_DEPTH) : LCW'(TABLE_ENTRIES))) begin
                        n_status  = ST_FULL;
                        n_o_total = kind_counted ? hist_cur : '0;
                    end else begin
                        ram_we    = 1'b1;
                        idx_wide  = 32'(r_bcount);
                        n_bcount  = r_bcount + LCW'(1);
                        n_status  = ST_BURNIN;
                        n_hist_we = kind_counted;
                        n_o_total = kind_counted ? hist_inc : '0;
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
                if (n_done) begin
                    n_o_cyl  = '0;
                    n_o_trk  = '0;
                    n_o_sec  = '0;
                    n_o_idx  = idx_wide[IDX_W-1:0];
                    n_o_bad  = bad_wide[CNT_W-1:0];
                    n_o_skip = skip_wide[CNT_W-1:0];
                end
            end
            S_DIV_CYL: begin
                n_q    = div_q;
                n_rem  = div_rem;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_cyl   = div_q[CYL_W-1:0];
                    n_q     = BN_W'(div_rem);
                    n_rem   = '0;
                    n_dvs   = CYL_W'(spt_eff);
                    n_step  = '0;
                    n_state = S_DIV_TRK;
                end
            end
            S_DIV_TRK: begin
                n_q    = div_q;
                n_rem  = div_rem;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_trk   = div_q[TRK_W-1:0];
                    n_sec   = div_rem[SEC_W-1:0];
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_hist_we = kind_counted;
                n_o_total = kind_counted ? hist_inc : '0;
                n_status  = ST_BAD;
                if (r_skip_drive) begin
                    if (r_skip >= TCW'(TABLE_ENTRIES)) begin
                        n_status = ST_FULL;
                        to_bad   = 1'b0;
                    end else begin
                        new_track = (r_skip == '0) || (r_last_trk != r_trk)
                                    || (r_last_cyl != r_cyl);
                        if (new_track) begin
                            to_bad = 1'b0;
                            if (r_sec == spt_eff - TRK_W'(1)) begin
                                n_status = ST_SPARE;
                            end else begin
                                idx_wide   = 32'(r_skip);
                                n_skip     = r_skip + TCW'(1);
                                n_last_cyl = r_cyl;
                                n_last_trk = r_trk;
                                n_status   = ST_SKIP;
                            end
                        end
                    end
                end
                if (to_bad) begin
                    if (r_bad >= TCW'(TABLE_ENTRIES)) begin
                        n_status = ST_FULL;
                    end else begin
                        idx_wide = 32'(r_bad);
                        n_bad    = r_bad + TCW'(1);
                        n_status = ST_BAD;
                    end
                end
                bad_wide  = 32'(n_bad);
                skip_wide = 32'(n_skip);
                n_o_cyl   = r_cyl;
                n_o_trk   = r_trk;
                n_o_sec   = r_sec;
                n_o_idx   = idx_wide[IDX_W-1:0];
                n_o_bad   = bad_wide[CNT_W-1:0];
                n_o_skip  = skip_wide[CNT_W-1:0];
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_cylinder    = r_o_cyl;
    assign o_track       = r_o_trk;
    assign o_sector      = r_o_sec;
    assign o_entry_index = r_o_idx;
    assign o_bad_count   = r_o_bad;
    assign o_skip_count  = r_o_skip;
    assign o_kind_total  = r_o_total;

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("Result beat without a command in progress.");

    a_list_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcount <= LCW'(LIST_DEPTH))
        else $error("Burn-in list count beyond its depth.");

    a_burnin_no_geometry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_BURNIN || o_status == ST_DUP))
            |-> (o_cylinder == '0 && o_track == '0 && o_sector == '0))
        else $error("Burn-in result carries geometry.");

    a_table_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bad <= TCW'(TABLE_ENTRIES) && r_skip <= TCW'(TABLE_ENTRIES))
        else $error("Table count beyond the table size.");

endmodule
